@@ rtl/core/tprm_pkg.sv @@
// Shared types and constants for the touchpad to relative mouse core.
`default_nettype none

package tprm_pkg;

    // Coordinate bits that take part in the delta; higher bits are ignored
    localparam int COORD_BITS  = 16;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int DELTA_W     = 8;
    localparam int DELTA_LIMIT = 127;
    localparam int REPORT_W    = 1 + 2 * DELTA_W;

    // Stream word layout, input side
    localparam int IN_TDATA_W  = 40;
    localparam int POS_X_LSB   = 0;
    localparam int POS_Y_LSB   = 16;
    localparam int CONTACT_BIT = 32;
    localparam int PAD_BIT     = 33;
    localparam int CLICK_BIT   = 34;
    localparam int CTRL_BIT    = 35;
    localparam int SHIFT_BIT   = 36;

    // Stream word layout, output side
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - REPORT_W - 1;

    // One touchpad scan
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  contact;
        logic                  pad;
        logic                  click;
        logic                  ctrl;
        logic                  shift;
    } t_scan;

    // State carried from scan to scan
    typedef struct packed {
        logic [COORD_BITS-1:0] last_x;
        logic [COORD_BITS-1:0] last_y;
        logic                  had_contact;
        logic                  y_flip;
        logic                  gesture_was_down;
        logic [REPORT_W-1:0]   sent_report;
    } t_state;

    // One mouse report
    typedef struct packed {
        logic                      changed;
        logic signed [DELTA_W-1:0] delta_y;
        logic signed [DELTA_W-1:0] delta_x;
        logic                      left_button;
    } t_report;

    localparam t_state STATE_RESET = '{
        last_x:           '0,
        last_y:           '0,
        had_contact:      1'b0,
        y_flip:           1'b1,
        gesture_was_down: 1'b0,
        sent_report:      '0
    };

endpackage

`default_nettype wire

@@ rtl/core/tprm_calc.sv @@
// Per-scan report arithmetic: gesture toggle, delta, halving, clamping, change detect.
`default_nettype none

module tprm_calc (
    input  wire tprm_pkg::t_scan  i_scan,
    input  wire tprm_pkg::t_state i_state,
    output tprm_pkg::t_report     o_report,
    output tprm_pkg::t_state      o_state
);

    localparam logic signed [tprm_pkg::DIFF_W-1:0] LIM_P =
        tprm_pkg::DIFF_W'(tprm_pkg::DELTA_LIMIT);
    localparam logic signed [tprm_pkg::DIFF_W-1:0] LIM_N = -LIM_P;

    // Halve toward zero, then saturate to the report range
    function automatic logic signed [tprm_pkg::DELTA_W-1:0] scale_clamp(
        input logic signed [tprm_pkg::DIFF_W-1:0] d
    );
        logic signed [tprm_pkg::DIFF_W-1:0] h;
        h = d >>> 1;
        if (d[tprm_pkg::DIFF_W-1] && d[0]) begin
            h = h + tprm_pkg::DIFF_W'(1);
        end
        if (h > LIM_P) begin
            scale_clamp = tprm_pkg::DELTA_W'(tprm_pkg::DELTA_LIMIT);
        end else if (h < LIM_N) begin
            scale_clamp = tprm_pkg::DELTA_W'(-tprm_pkg::DELTA_LIMIT);
        end else begin
            scale_clamp = h[tprm_pkg::DELTA_W-1:0];
        end
    endfunction

    logic                                button;
    logic                                gesture;
    logic                                flip;
    logic                                moving;
    logic signed [tprm_pkg::DIFF_W-1:0]  diff_x;
    logic signed [tprm_pkg::DIFF_W-1:0]  diff_y_raw;
    logic signed [tprm_pkg::DIFF_W-1:0]  diff_y;
    logic signed [tprm_pkg::DELTA_W-1:0] dx;
    logic signed [tprm_pkg::DELTA_W-1:0] dy;
    logic [tprm_pkg::REPORT_W-1:0]       word;

    // Button, gesture edge and the flip flag that applies to this scan
    always_comb begin
        button  = i_scan.pad | i_scan.click;
        gesture = i_scan.ctrl & i_scan.shift & button;
        flip    = i_state.y_flip ^ (gesture & ~i_state.gesture_was_down);
    end

    // Form the deltas against the previous contact position
    always_comb begin
        moving     = i_scan.contact & i_state.had_contact;
        diff_x     = $signed({1'b0, i_scan.x}) - $signed({1'b0, i_state.last_x});
        diff_y_raw = $signed({1'b0, i_scan.y}) - $signed({1'b0, i_state.last_y});
        diff_y     = flip ? -diff_y_raw : diff_y_raw;
        dx         = moving ? scale_clamp(diff_x) : '0;
        dy         = moving ? scale_clamp(diff_y) : '0;
        word       = {dy, dx, button};
    end

    // Build the report and the state left for the next scan
    always_comb begin
        o_report.left_button = button;
        o_report.delta_x     = dx;
        o_report.delta_y     = dy;
        o_report.changed     = (word != i_state.sent_report);

        o_state.last_x           = i_scan.contact ? i_scan.x : i_state.last_x;
        o_state.last_y           = i_scan.contact ? i_scan.y : i_state.last_y;
        o_state.had_contact      = i_scan.contact;
        o_state.y_flip           = flip;
        o_state.gesture_was_down = gesture;
        o_state.sent_report      = word;
    end

endmodule

`default_nettype wire

@@ rtl/core/touchpad_to_relative_mouse_core.sv @@
// Top level: touchpad scan stream in, relative mouse report stream out.
// Takes one touchpad scan word per cycle and returns one mouse report word for each;
// throughput is one word per clock while the sink does not stall. An accepted scan is
// held in the scan input register and moves into the report register once that is
// free, where its report waits for the sink (scan input register, then report
// register). The report and scan registers are separate stages, so one new scan can be
// taken while a finished report waits for the sink. Scan state (last position,
// contact, flip flag, last report sent) updates as a scan moves into the report register.
// The Y delta is negated while the flip flag is set; it starts set after reset and is
// toggled by pressing ctrl, shift and a button together.
`default_nettype none

module touchpad_to_relative_mouse_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: pos_x[15:0], pos_y[31:16], contact[32], pad_pressed[33], click_key[34],
    //        ctrl_key[35], shift_key[36], zero[39:37]
    input  wire  [tprm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // tdata: left_button[0], delta_x[8:1], delta_y[16:9], report_changed[17], zero[23:18]
    output logic [tprm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    tprm_pkg::t_scan   r_in;
    logic              r_in_valid;
    tprm_pkg::t_report r_out;
    logic              r_out_valid;
    tprm_pkg::t_state  r_state;
    tprm_pkg::t_report n_out;
    tprm_pkg::t_state  n_state;
    tprm_pkg::t_scan   in_scan;
    logic              out_free;
    logic              advance;
    logic              in_take;

    // Handshake control
    always_comb begin
        out_free        = ~r_out_valid | i_m_axis_tready;
        advance         = r_in_valid & out_free;
        o_s_axis_tready = ~r_in_valid | out_free;
        in_take         = i_s_axis_tvalid & o_s_axis_tready;
    end

    // Unpack the incoming word
    always_comb begin
        in_scan.x       = i_s_axis_tdata[tprm_pkg::POS_X_LSB +: tprm_pkg::COORD_BITS];
        in_scan.y       = i_s_axis_tdata[tprm_pkg::POS_Y_LSB +: tprm_pkg::COORD_BITS];
        in_scan.contact = i_s_axis_tdata[tprm_pkg::CONTACT_BIT];
        in_scan.pad     = i_s_axis_tdata[tprm_pkg::PAD_BIT];
        in_scan.click   = i_s_axis_tdata[tprm_pkg::CLICK_BIT];
        in_scan.ctrl    = i_s_axis_tdata[tprm_pkg::CTRL_BIT];
        in_scan.shift   = i_s_axis_tdata[tprm_pkg::SHIFT_BIT];
    end

    tprm_calc u_calc (
        .i_scan   (r_in),
        .i_state  (r_state),
        .o_report (n_out),
        .o_state  (n_state)
    );

    // Input register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture the scan word
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_scan;
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the report until the sink takes it
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Advance scan state as each scan is reported
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tprm_pkg::STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{tprm_pkg::OUT_PAD_W{1'b0}}, r_out};

    // Reported deltas never reach the most negative code
    a_delta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.delta_x != 8'sh80 && r_out.delta_y != 8'sh80))
        else $error("delta outside saturation range");

    // A scan without contact leaves no contact for the next one
    a_contact_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in.contact) |=> !r_state.had_contact)
        else $error("had_contact not cleared after contact loss");

    // A flagged report is the one recorded as sent
    a_sent_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.changed) |->
            (r_state.sent_report == {r_out.delta_y, r_out.delta_x, r_out.left_button}))
        else $error("sent report differs from flagged report");

    // Scan state moves only with a scan
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("scan state changed without a scan");

    // Without motion history the deltas are zero
    a_no_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !(r_in.contact && r_state.had_contact)) |=>
            (r_out.delta_x == '0 && r_out.delta_y == '0))
        else $error("delta produced without two contact scans");

endmodule

`default_nettype wire

@@ tb/sv/tb_touchpad_to_relative_mouse_core.sv @@
// Testbench for the touchpad to relative mouse core: scan stream in, checked report stream out.
`timescale 1ns / 1ps

module tb_touchpad_to_relative_mouse_core;
    import tprm_pkg::*;

    typedef enum {SINK_FREE, SINK_RANDOM, SINK_PERIODIC} t_sink_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // tdata: pos_x[15:0], pos_y[31:16], contact[32], pad_pressed[33], click_key[34],
    //        ctrl_key[35], shift_key[36], zero[39:37]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // tdata: left_button[0], delta_x[8:1], delta_y[16:9], report_changed[17], zero[23:18]
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    touchpad_to_relative_mouse_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Predicted reports, oldest first
    t_report pending_reports[$];

    // Mirror of the core's scan state
    logic [COORD_BITS-1:0] prev_x;
    logic [COORD_BITS-1:0] prev_y;
    logic                  prev_contact;
    logic                  flip_y;
    logic                  chord_held;
    logic [REPORT_W-1:0]   last_sent;

    int unsigned burst_left;
    int unsigned scans_sent;
    int unsigned reports_checked;
    int unsigned mismatches;
    int unsigned flip_toggles;
    int unsigned clamped_deltas;
    int unsigned changed_reports;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up after a generous fixed time
    initial begin
        #10ms;
        $display("timeout: %0d reports still outstanding", pending_reports.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Halve toward zero, then clamp to the report range
    function automatic int scale_motion(input int d);
        int h;
        h = d / 2;
        if (h > DELTA_LIMIT || h < -DELTA_LIMIT) clamped_deltas++;
        if (h > DELTA_LIMIT) h = DELTA_LIMIT;
        else if (h < -DELTA_LIMIT) h = -DELTA_LIMIT;
        return h;
    endfunction

    // Work out the report for one scan and advance the mirrored state
    function automatic t_report predict_report(input t_scan s);
        logic    button;
        logic    chord;
        int      dx;
        int      dy;
        t_report r;
        logic [REPORT_W-1:0] bits;
        button = s.pad | s.click;
        chord  = s.ctrl & s.shift & button;
        if (chord && !chord_held) begin
            flip_y = ~flip_y;
            flip_toggles++;
        end
        chord_held = chord;
        dx = 0;
        dy = 0;
        if (s.contact && prev_contact) begin
            dx = int'(s.x) - int'(prev_x);
            dy = int'(s.y) - int'(prev_y);
            if (flip_y) dy = -dy;
            dx = scale_motion(dx);
            dy = scale_motion(dy);
        end
        if (s.contact) begin
            prev_x = s.x;
            prev_y = s.y;
        end
        prev_contact = s.contact;
        r.left_button = button;
        r.delta_x     = dx[DELTA_W-1:0];
        r.delta_y     = dy[DELTA_W-1:0];
        bits          = {r.delta_y, r.delta_x, r.left_button};
        r.changed     = (bits != last_sent);
        if (r.changed) begin
            last_sent = bits;
            changed_reports++;
        end
        return r;
    endfunction

    function automatic t_scan mk_scan(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                                      input logic contact, input logic pad, input logic click,
                                      input logic ctrl, input logic shift);
        t_scan s;
        s.x       = x;
        s.y       = y;
        s.contact = contact;
        s.pad     = pad;
        s.click   = click;
        s.ctrl    = ctrl;
        s.shift   = shift;
        return s;
    endfunction

    // Offer one scan word; bursts of random length with random pauses between them
    task automatic send_scan(input t_scan s);
        int unsigned           gap;
        logic [IN_TDATA_W-1:0] word;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        word = '0;
        word[POS_X_LSB +: COORD_BITS] = s.x;
        word[POS_Y_LSB +: COORD_BITS] = s.y;
        word[CONTACT_BIT] = s.contact;
        word[PAD_BIT]     = s.pad;
        word[CLICK_BIT]   = s.click;
        word[CTRL_BIT]    = s.ctrl;
        word[SHIFT_BIT]   = s.shift;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        // hold the word until the core takes it
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_reports.push_back(predict_report(s));
        scans_sent++;
        @(negedge i_clk);
    endtask

    // Check each report word against the oldest prediction
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_report'(o_m_axis_tdata[REPORT_W:0]);
            reports_checked++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: report %h with nothing outstanding", $realtime, got);
            end else begin
                want = pending_reports.pop_front();
                if (got.left_button !== want.left_button || got.delta_x !== want.delta_x ||
                    got.delta_y !== want.delta_y || got.changed !== want.changed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: report %0d: expected btn=%b dx=%0d dy=%0d chg=%b, got btn=%b dx=%0d dy=%0d chg=%b",
                                 $realtime, reports_checked, want.left_button, want.delta_x,
                                 want.delta_y, want.changed, got.left_button, got.delta_x,
                                 got.delta_y, got.changed);
                end
            end
        end
    end

    // Sink: free-running, random or periodic stalls, switched in stretches
    initial begin
        t_sink_mode  mode;
        int unsigned span;
        int unsigned period;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode   = t_sink_mode'($urandom_range(0, 2));
            span   = $urandom_range(4, 60);
            period = $urandom_range(2, 5);
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                case (mode)
                    SINK_FREE: begin
                        i_m_axis_tready <= 1'b1;
                    end
                    SINK_RANDOM: begin
                        i_m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_m_axis_tready <= ((c % period) == 0);
                    end
                endcase
            end
        end
    end

    // Idle scans straight after reset leave the report at all zero
    task automatic test_reset_report();
        send_scan(mk_scan(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    // Small moves: truncation toward zero, Y negation, unchanged report
    task automatic test_delta_scaling();
        send_scan(mk_scan(16'd1000, 16'd1000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd1001, 16'd999,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd1004, 16'd1003, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd1001, 16'd1010, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd1001, 16'd1010, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd1001, 16'd1010, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    // Full-scale jumps and the clamp boundary either side of 127
    task automatic test_saturation();
        send_scan(mk_scan(16'd0,    16'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd0,    16'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd254,  16'd256,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd0,    16'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    // A lifted finger breaks the stroke; the next touch starts afresh
    task automatic test_contact_loss();
        send_scan(mk_scan(16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd500,  16'd500,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd520,  16'd480,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    // Both click sources, partial chords, and the flip toggling on the chord edge only
    task automatic test_buttons_and_chord();
        send_scan(mk_scan(16'd520, 16'd480, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd520, 16'd480, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        send_scan(mk_scan(16'd520, 16'd480, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
        send_scan(mk_scan(16'd530, 16'd490, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        send_scan(mk_scan(16'd540, 16'd500, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
        send_scan(mk_scan(16'd540, 16'd510, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_scan(mk_scan(16'd540, 16'd520, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_scan(mk_scan(16'd540, 16'd530, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        send_scan(mk_scan(16'd540, 16'd540, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    endtask

    // Finger strokes with random content, lifts between them and chords now and then
    task automatic test_random_strokes(input int unsigned n_scans);
        int unsigned           done;
        int unsigned           stroke_len;
        int                    reach;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  pad;
        logic                  click;
        logic                  chord;
        done = 0;
        while (done < n_scans) begin
            repeat ($urandom_range(0, 2)) begin
                send_scan(mk_scan(16'($urandom), 16'($urandom), 1'b0,
                                  1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0));
                done++;
            end
            x          = 16'($urandom);
            y          = 16'($urandom);
            pad        = ($urandom_range(0, 3) == 0);
            click      = ($urandom_range(0, 5) == 0);
            chord      = 1'b0;
            stroke_len = $urandom_range(2, 40);
            case ($urandom_range(0, 2))
                0:       reach = 3;
                1:       reach = 40;
                default: reach = 300;
            endcase
            for (int k = 0; k < stroke_len; k++) begin
                // mostly small steps, now and then a jump across the pad
                if ($urandom_range(0, 15) == 0) begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end else begin
                    x = x + 16'($urandom_range(0, 2 * reach)) - 16'(reach);
                    y = y + 16'($urandom_range(0, 2 * reach)) - 16'(reach);
                end
                if ($urandom_range(0, 7) == 0) pad = ~pad;
                if ($urandom_range(0, 11) == 0) click = ~click;
                if ($urandom_range(0, 9) == 0) chord = ~chord;
                send_scan(mk_scan(x, y, 1'b1, pad, click,
                                  chord | ($urandom_range(0, 9) == 0),
                                  chord | ($urandom_range(0, 9) == 0)));
                done++;
            end
        end
    endtask

    // Unstructured scans with every field random
    task automatic test_random_noise(input int unsigned n_scans);
        repeat (n_scans) begin
            send_scan(mk_scan(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        prev_x          = '0;
        prev_y          = '0;
        prev_contact    = 1'b0;
        flip_y          = 1'b1;
        chord_held      = 1'b0;
        last_sent       = '0;
        burst_left      = 0;
        scans_sent      = 0;
        reports_checked = 0;
        mismatches      = 0;
        flip_toggles    = 0;
        clamped_deltas  = 0;
        changed_reports = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_report();
        test_delta_scaling();
        test_saturation();
        test_contact_loss();
        test_buttons_and_chord();
        test_random_strokes(1500);
        test_random_noise(400);
        i_s_axis_tvalid <= 1'b0;

        // drain outstanding reports, then allow for the pipeline
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d scans and %0d reports (%0d changed), %0d flip toggles, %0d clamped deltas",
                 scans_sent, reports_checked, changed_reports, flip_toggles, clamped_deltas);
        $display("mismatches counted: %0d", mismatches);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tprm_pkg.sv
rtl/core/tprm_calc.sv
rtl/core/touchpad_to_relative_mouse_core.sv
tb/sv/tb_touchpad_to_relative_mouse_core.sv
